// ===== hdl/ecff_pkg.sv =====
// Package of the extent cluster fragment finder.
// Holds the block width constants and the beat types of both channels.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ecff_pkg;

  localparam int unsigned BlockBits = 48;
  localparam int unsigned LenBits   = 32;
  localparam int unsigned ShiftBits = 5;

  localparam logic [ShiftBits-1:0] ShiftReset = ShiftBits'(8);

  typedef struct packed {
    logic [BlockBits-1:0] extent_logical;
    logic [BlockBits-1:0] extent_physical;
    logic [LenBits-1:0]   extent_length;
    logic                 delalloc;
    logic                 last_extent;
  } ext_item_t;

  typedef struct packed {
    logic [BlockBits-1:0] fragmented_cluster;
  } res_item_t;

endpackage

`default_nettype wire

// ===== hdl/ecff_in_if.sv =====
// Valid/ready channel that carries one extent beat.
// Depends on ecff_pkg for the payload type.
`default_nettype none

interface ecff_in_if;
  import ecff_pkg::*;

  logic      valid;
  logic      ready;
  ext_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/ecff_out_if.sv =====
// Valid/ready channel that carries one fragmented cluster beat.
// Depends on ecff_pkg for the payload type.
`default_nettype none

interface ecff_out_if;
  import ecff_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/extent_cluster_fragment_finder_top.sv =====
// Extent cluster fragment finder, top level.
// The result beat of a cluster is registered in the output register after stage one.
// Throughput: one extent beat per cycle unless the input stalls; tracking updates per beat.
// Back pressure reaches the input only when both registers are full and output is blocked.
// Reset (asynchronous, active low) clears the cluster tracking and sets cluster_shift to 8.
// Depends on ecff_pkg, ecff_in_if and ecff_out_if.
`default_nettype none

module extent_cluster_fragment_finder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cluster_shift_we_i,
  input  wire logic [ecff_pkg::ShiftBits-1:0] cluster_shift_i,
  ecff_in_if.sink                            extent_i,
  ecff_out_if.source                         result_o
);
  import ecff_pkg::*;

  // Stage one holds everything about the extent that does not depend on the
  // tracking state: the clipped last block, the values the extent would leave
  // as next expected blocks, and the cluster it starts and ends in.
  typedef struct packed {
    logic [BlockBits-1:0] lg;
    logic [BlockBits-1:0] ph;
    logic [BlockBits-1:0] last;
    logic [BlockBits-1:0] nlog;
    logic [BlockBits-1:0] nphys;
    logic [BlockBits-1:0] clu;
    logic [BlockBits-1:0] cstart;
    logic [BlockBits-1:0] clast;
    logic [BlockBits-1:0] clu_end;
    logic                 reopen_nz;
    logic                 usable;
    logic                 len_nz;
    logic                 last_extent;
  } s1_t;

  logic [ShiftBits-1:0] shift_q;

  logic s1_valid_q, s1_valid_d;
  s1_t  s1_q, s1_d;

  logic      out_valid_q, out_valid_d;
  res_item_t out_q;

  logic [BlockBits-1:0] oc_q, oc_d;
  logic [BlockBits-1:0] nl_q, nl_d;
  logic [BlockBits-1:0] np_q, np_d;
  logic                 sc_q, sc_d;
  logic                 sg_q, sg_d;
  logic                 open_q, open_d;

  logic out_free, s1_fire, in_fire, res_load;

  // Stage-one arithmetic.
  logic [LenBits-1:0]   lenm1;
  logic [BlockBits:0]   sum_last;
  logic                 clipped;
  logic [BlockBits-1:0] last_blk;
  logic [BlockBits-1:0] nlog;
  logic [BlockBits-1:0] mask_s;

  // Stage-two tracking update.
  logic                 new_clu;
  logic [BlockBits-1:0] oc_e, nl_e, np_e;
  logic                 sc_e, sg_e;
  logic                 brk, sc1, sg1, reach, emit;

  // Handshake: the output register frees itself when its beat is taken, and
  // stage one moves whenever the output slot is free.
  assign out_free       = !out_valid_q || result_o.ready;
  assign s1_fire        = s1_valid_q && out_free;
  assign extent_i.ready = !s1_valid_q || out_free;
  assign in_fire        = extent_i.valid && extent_i.ready;

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // An extent that runs past the last block of the address space is cut there.
  // Its end is then the top block and the next logical block wraps to zero;
  // the continuing physical block is the start plus the clipped length.
  always_comb begin
    lenm1    = extent_i.payload.extent_length - LenBits'(1);
    sum_last = {1'b0, extent_i.payload.extent_logical}
             + {{(BlockBits + 1 - LenBits){1'b0}}, lenm1};
    clipped  = sum_last[BlockBits];
    last_blk = clipped ? {BlockBits{1'b1}} : sum_last[BlockBits-1:0];
    nlog     = clipped ? '0
             : extent_i.payload.extent_logical
               + {{(BlockBits - LenBits){1'b0}}, extent_i.payload.extent_length};
    mask_s   = ~({BlockBits{1'b1}} << shift_q);

    s1_d.lg          = extent_i.payload.extent_logical;
    s1_d.ph          = extent_i.payload.extent_physical;
    s1_d.last        = last_blk;
    s1_d.nlog        = nlog;
    s1_d.nphys       = clipped
                     ? extent_i.payload.extent_physical - extent_i.payload.extent_logical
                     : extent_i.payload.extent_physical
                       + {{(BlockBits - LenBits){1'b0}}, extent_i.payload.extent_length};
    s1_d.clu         = extent_i.payload.extent_logical >> shift_q;
    s1_d.cstart      = extent_i.payload.extent_logical & ~mask_s;
    s1_d.clast       = extent_i.payload.extent_logical | mask_s;
    s1_d.clu_end     = last_blk >> shift_q;
    s1_d.reopen_nz   = |(nlog & mask_s);
    s1_d.usable      = (extent_i.payload.extent_physical != '0)
                     && !extent_i.payload.delalloc;
    s1_d.len_nz      = extent_i.payload.extent_length != '0;
    s1_d.last_extent = extent_i.payload.last_extent;
  end

  assign s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  // Stage two: an extent in another cluster than the tracked one opens its
  // own cluster first. Then the extent is checked for continuity, and if it
  // reaches the end of the cluster the cluster is judged and closed; any
  // remainder that ends inside a later cluster opens that cluster.
  always_comb begin
    new_clu = !open_q || (s1_q.clu != oc_q);
    oc_e    = new_clu ? s1_q.clu    : oc_q;
    nl_e    = new_clu ? s1_q.cstart : nl_q;
    np_e    = new_clu ? '0          : np_q;
    sc_e    = new_clu ? 1'b1        : sc_q;
    sg_e    = new_clu ? 1'b0        : sg_q;

    brk   = (s1_q.lg != nl_e) || !s1_q.usable;
    sc1   = brk ? 1'b0 : sc_e;
    sg1   = (!brk && (s1_q.lg != s1_q.cstart) && (s1_q.ph != np_e)) ? 1'b1 : sg_e;
    reach = s1_q.last >= s1_q.clast;
    emit  = 1'b0;

    oc_d   = oc_q;
    nl_d   = nl_q;
    np_d   = np_q;
    sc_d   = sc_q;
    sg_d   = sg_q;
    open_d = open_q;

    if (s1_fire && s1_q.len_nz) begin
      if (reach) begin
        emit   = sc1 && sg1;
        oc_d   = oc_e;
        nl_d   = nl_e;
        np_d   = np_e;
        sc_d   = 1'b0;
        sg_d   = 1'b0;
        open_d = 1'b0;
        if ((s1_q.last != s1_q.clast) && s1_q.reopen_nz) begin
          oc_d   = s1_q.clu_end;
          nl_d   = s1_q.nlog;
          np_d   = s1_q.nphys;
          sc_d   = s1_q.usable;
          open_d = 1'b1;
        end
      end else begin
        oc_d   = oc_e;
        nl_d   = s1_q.nlog;
        np_d   = s1_q.nphys;
        sc_d   = sc1;
        sg_d   = sg1;
        open_d = 1'b1;
      end
    end

    // The final extent of a file drops whatever cluster is still tracked.
    if (s1_fire && s1_q.last_extent) begin
      oc_d   = '0;
      nl_d   = '0;
      np_d   = '0;
      sc_d   = 1'b0;
      sg_d   = 1'b0;
      open_d = 1'b0;
    end
  end

  assign res_load    = s1_fire && emit;
  assign out_valid_d = res_load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= ShiftReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      oc_q        <= '0;
      nl_q        <= '0;
      np_q        <= '0;
      sc_q        <= 1'b0;
      sg_q        <= 1'b0;
      open_q      <= 1'b0;
    end else begin
      if (cluster_shift_we_i) begin
        shift_q <= cluster_shift_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      oc_q        <= oc_d;
      nl_q        <= nl_d;
      np_q        <= np_d;
      sc_q        <= sc_d;
      sg_q        <= sg_d;
      open_q      <= open_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (res_load) begin
      out_q.fragmented_cluster <= oc_e;
    end
  end

`ifndef SYNTH
  // The last extent of a file leaves no cluster tracked.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_q.last_extent |=> !open_q)
    else $error("tracking not cleared after last extent");

  // A zero-length extent never produces a result.
  a_no_result_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> s1_q.len_nz)
    else $error("result from zero-length extent");

  // The input stalls only when both registers hold beats and the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !extent_i.ready |-> s1_valid_q && out_valid_q && !result_o.ready)
    else $error("input stalled without cause");

  // With no cluster tracked the continuity and gap flags are clear.
  a_closed_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> !sc_q && !sg_q)
    else $error("flags set with no open cluster");
`endif

endmodule

`default_nettype wire
